// ===== hdl/tatp_pkg.sv =====
// ----------------------------------------------------------------------------
// tatp_pkg: shared types and constants of the type-annotation target parser
// Parse phases, result kinds, error codes, the per-tag field table and the
// result word that the parse step hands to the output register.
// ----------------------------------------------------------------------------
package tatp_pkg;

  // Default width of the internal byte counter
  localparam int LENGTH_BITS_DEFAULT = 19;
  // Largest width the byte counter may take
  localparam int LENGTH_BITS_MAX = 24;
  // Width of the reported length
  localparam int LEN_OUT_BITS = 19;
  localparam logic [LEN_OUT_BITS-1:0] LEN_OUT_MAX = '1;

  // Bytes in one local-variable table entry
  localparam logic [2:0] TABLE_ENTRY_BYTES = 3'd6;
  // Bytes in a table length field and in a path entry
  localparam logic [2:0] PAIR_BYTES = 3'd2;
  // Only this path kind may carry a nonzero argument
  localparam logic [7:0] MAX_PATH_KIND = 8'd3;

  // Tags whose two field bytes are two separate single-byte indices
  localparam logic [7:0] TAG_CLASS_TYPE_PARAM_BOUND  = 8'h11;
  localparam logic [7:0] TAG_METHOD_TYPE_PARAM_BOUND = 8'h12;

  typedef enum logic [2:0] {
    PH_TAG    = 3'd0,
    PH_FIELDS = 3'd1,
    PH_TLEN   = 3'd2,
    PH_TENTRY = 3'd3,
    PH_PLEN   = 3'd4,
    PH_PENTRY = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TARGET = 2'd0,
    KIND_TABLE  = 2'd1,
    KIND_PATH   = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_TAG  = 2'd1,
    ERR_BAD_KIND = 2'd2,
    ERR_BAD_ARG  = 2'd3
  } err_t;

  // Field layout of a tag; the first four carry the fixed byte count
  typedef enum logic [2:0] {
    NEED_0     = 3'd0,
    NEED_1     = 3'd1,
    NEED_2     = 3'd2,
    NEED_3     = 3'd3,
    NEED_TABLE = 3'd4,
    NEED_BAD   = 3'd5
  } need_t;

  typedef struct packed {
    logic                    valid;
    kind_t                   kind;
    logic [7:0]              tag;
    logic [15:0]             a;
    logic [15:0]             b;
    logic [15:0]             c;
    logic [LEN_OUT_BITS-1:0] total;
    err_t                    err;
    logic                    last;
  } result_t;

  // Field layout for each target-type tag
  function automatic need_t field_need(input logic [7:0] tag);
    need_t n;
    case (tag) inside
      8'h00, 8'h01, 8'h16:                            n = NEED_1;
      8'h10, 8'h11, 8'h12, 8'h17, 8'h42,
      8'h43, 8'h44, 8'h45, 8'h46:                     n = NEED_2;
      8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B:              n = NEED_3;
      8'h13, 8'h14, 8'h15:                            n = NEED_0;
      8'h40, 8'h41:                                   n = NEED_TABLE;
      default:                                        n = NEED_BAD;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/tatp_step.sv =====
// ----------------------------------------------------------------------------
// tatp_step: parse state and one-byte parse step
// Holds the parse state and works out, for one byte, the next state and the
// result word (if any) that the byte completes.
// ----------------------------------------------------------------------------
module tatp_step #(
  parameter int LENGTH_BITS = tatp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [7:0]        data_byte,
  output tatp_pkg::result_t res
);

  tatp_pkg::phase_t         phase, phase_next;
  logic [7:0]               tag, tag_next;
  logic [2:0]               fbc, fbc_next;
  logic [15:0]              tleft, tleft_next;
  logic [7:0]               pleft, pleft_next;
  logic [47:0]              asm_f, asm_next;
  logic [LENGTH_BITS-1:0]   bytes, bytes_next;

  logic [47:0]              shifted;
  logic [LENGTH_BITS-1:0]   bytes_inc;
  logic [2:0]               fbc_inc;
  logic [tatp_pkg::LENGTH_BITS_MAX-1:0] bytes_ext;
  logic [tatp_pkg::LEN_OUT_BITS-1:0]    len_now;
  tatp_pkg::need_t          need_new, need_held;
  logic [7:0]               path_kind;
  logic [15:0]              tleft_dec;
  logic [7:0]               pleft_dec;

  // Shared pieces of the step
  assign shifted   = {asm_f[39:0], data_byte};
  assign bytes_inc = (bytes != '1) ? bytes + 1'b1 : bytes;
  assign fbc_inc   = fbc + 3'd1;
  assign need_new  = tatp_pkg::field_need(data_byte);
  assign need_held = tatp_pkg::field_need(tag);
  assign path_kind = asm_f[7:0];
  assign tleft_dec = tleft - 16'd1;
  assign pleft_dec = pleft - 8'd1;

  // Clamp the running count to the reported width
  always_comb begin
    bytes_ext = tatp_pkg::LENGTH_BITS_MAX'(bytes_next);
    if (bytes_ext > tatp_pkg::LENGTH_BITS_MAX'(tatp_pkg::LEN_OUT_MAX)) begin
      len_now = tatp_pkg::LEN_OUT_MAX;
    end else begin
      len_now = bytes_ext[tatp_pkg::LEN_OUT_BITS-1:0];
    end
  end

  // Next state and result for the byte in hand
  always_comb begin
    phase_next = phase;
    tag_next   = tag;
    fbc_next   = fbc;
    tleft_next = tleft;
    pleft_next = pleft;
    asm_next   = shifted;
    bytes_next = bytes_inc;
    res        = '0;
    res.kind   = tatp_pkg::KIND_TARGET;
    res.err    = tatp_pkg::ERR_NONE;

    unique case (phase)
      tatp_pkg::PH_FIELDS: begin
        fbc_next = fbc_inc;
        if (fbc_inc >= 3'(need_held)) begin
          phase_next = tatp_pkg::PH_PLEN;
          fbc_next   = '0;
          res.valid  = 1'b1;
          case (need_held)
            tatp_pkg::NEED_1: res.a = {8'd0, shifted[7:0]};
            tatp_pkg::NEED_2: begin
              if (tag == tatp_pkg::TAG_CLASS_TYPE_PARAM_BOUND ||
                  tag == tatp_pkg::TAG_METHOD_TYPE_PARAM_BOUND) begin
                res.a = {8'd0, shifted[15:8]};
                res.b = {8'd0, shifted[7:0]};
              end else begin
                res.a = shifted[15:0];
              end
            end
            tatp_pkg::NEED_3: begin
              res.a = shifted[23:8];
              res.b = {8'd0, shifted[7:0]};
            end
            default: ;
          endcase
        end
      end

      tatp_pkg::PH_TLEN: begin
        fbc_next = fbc_inc;
        if (fbc_inc >= tatp_pkg::PAIR_BYTES) begin
          fbc_next   = '0;
          tleft_next = shifted[15:0];
          phase_next = (shifted[15:0] != '0) ? tatp_pkg::PH_TENTRY : tatp_pkg::PH_PLEN;
          res.valid  = 1'b1;
          res.b      = shifted[15:0];
        end
      end

      tatp_pkg::PH_TENTRY: begin
        fbc_next = fbc_inc;
        if (fbc_inc >= tatp_pkg::TABLE_ENTRY_BYTES) begin
          fbc_next   = '0;
          tleft_next = tleft_dec;
          if (tleft_dec == '0) begin
            phase_next = tatp_pkg::PH_PLEN;
          end
          res.valid = 1'b1;
          res.kind  = tatp_pkg::KIND_TABLE;
          res.a     = shifted[47:32];
          res.b     = shifted[31:16];
          res.c     = shifted[15:0];
        end
      end

      tatp_pkg::PH_PLEN: begin
        fbc_next   = '0;
        pleft_next = data_byte;
        if (data_byte == '0) begin
          phase_next = tatp_pkg::PH_TAG;
          res.valid  = 1'b1;
          res.kind   = tatp_pkg::KIND_END;
          res.total  = len_now;
          res.last   = 1'b1;
        end else begin
          phase_next = tatp_pkg::PH_PENTRY;
        end
      end

      tatp_pkg::PH_PENTRY: begin
        fbc_next = fbc_inc;
        if (fbc_inc >= tatp_pkg::PAIR_BYTES) begin
          fbc_next  = '0;
          res.valid = 1'b1;
          res.kind  = tatp_pkg::KIND_PATH;
          res.a     = {8'd0, path_kind};
          res.b     = {8'd0, data_byte};
          if (data_byte != '0 && path_kind != tatp_pkg::MAX_PATH_KIND) begin
            // argument on a kind that takes none
            phase_next = tatp_pkg::PH_TAG;
            res.err    = tatp_pkg::ERR_BAD_ARG;
            res.total  = len_now;
            res.last   = 1'b1;
          end else if (path_kind > tatp_pkg::MAX_PATH_KIND) begin
            phase_next = tatp_pkg::PH_TAG;
            res.err    = tatp_pkg::ERR_BAD_KIND;
            res.total  = len_now;
            res.last   = 1'b1;
          end else begin
            pleft_next = pleft_dec;
            if (pleft_dec == '0) begin
              // final entry rides in the end word
              phase_next = tatp_pkg::PH_TAG;
              res.kind   = tatp_pkg::KIND_END;
              res.c      = 16'd1;
              res.total  = len_now;
              res.last   = 1'b1;
            end
          end
        end
      end

      default: begin
        // Expecting a tag: start a new record
        tag_next   = data_byte;
        bytes_next = LENGTH_BITS'(1);
        fbc_next   = '0;
        asm_next   = '0;
        tleft_next = '0;
        pleft_next = '0;
        case (need_new)
          tatp_pkg::NEED_BAD: begin
            phase_next = tatp_pkg::PH_TAG;
            res.valid  = 1'b1;
            res.err    = tatp_pkg::ERR_BAD_TAG;
            res.total  = len_now;
            res.last   = 1'b1;
          end
          tatp_pkg::NEED_TABLE: phase_next = tatp_pkg::PH_TLEN;
          tatp_pkg::NEED_0: begin
            phase_next = tatp_pkg::PH_PLEN;
            res.valid  = 1'b1;
          end
          default: phase_next = tatp_pkg::PH_FIELDS;
        endcase
      end
    endcase

    res.tag = tag_next;
  end

  // Hold parse state; advance on each byte taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tatp_pkg::PH_TAG;
      tag   <= '0;
      fbc   <= '0;
      tleft <= '0;
      pleft <= '0;
      asm_f <= '0;
      bytes <= '0;
    end else if (go) begin
      phase <= phase_next;
      tag   <= tag_next;
      fbc   <= fbc_next;
      tleft <= tleft_next;
      pleft <= pleft_next;
      asm_f <= asm_next;
      bytes <= bytes_next;
    end
  end

endmodule

// ===== hdl/type_annotation_target_parser_core.sv =====
// ----------------------------------------------------------------------------
// type_annotation_target_parser_core: type-annotation target record parser
// Takes a record one byte per word and gives target, table-entry, path-entry,
// end and error results.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   input   | in        | in_valid/in_stall  | data_byte
//   output  | out       | out_valid/out_stall| record_kind, target_type,
//           |           |                    | value_a/b/c, total_length,
//           |           |                    | error_code, last
//
// One byte per cycle while out_stall keeps no word; a byte is taken into
// the input register, then the parse step loads its result into the output
// register. A byte that completes no result still takes its parse step.
// in_stall rises only while a byte waits in the input register and the
// output register holds a word that out_stall keeps.
// rst (synchronous) empties both registers and returns the parser to
// expecting a target tag.
// ----------------------------------------------------------------------------
module type_annotation_target_parser_core #(
  parameter int LENGTH_BITS = tatp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  record_kind,
  output logic [7:0]  target_type,
  output logic [15:0] value_a,
  output logic [15:0] value_b,
  output logic [15:0] value_c,
  output logic [18:0] total_length,
  output logic [1:0]  error_code,
  output logic        last
);

  logic              hold_valid;
  logic [7:0]        hold_byte;
  logic              step_go;
  tatp_pkg::result_t step_res;
  tatp_pkg::result_t out_word;

  // Step when a byte is held and the output register can take a word
  assign step_go  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !step_go;

  // Hold the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte <= data_byte;
    end
  end

  tatp_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .go        (step_go),
    .data_byte (hold_byte),
    .res       (step_res)
  );

  // Load a result word; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go && step_res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && step_res.valid) begin
      out_word <= step_res;
    end
  end

  assign record_kind  = out_word.kind;
  assign target_type  = out_word.tag;
  assign value_a      = out_word.a;
  assign value_b      = out_word.b;
  assign value_c      = out_word.c;
  assign total_length = out_word.total;
  assign error_code   = out_word.err;
  assign last         = out_word.last;

endmodule

// ===== sim/type_annotation_target_parser_checker.sv =====
// ----------------------------------------------------------------------------
// type_annotation_target_parser_checker: result predictor and comparator
// Watches both channels of the target parser. Every byte taken on the input
// channel advances a private copy of the parse state and may queue one
// expected result word. Every word taken on the output channel is checked
// field by field against the oldest queued word. Failures are counted and
// the count, with the number of words still awaited, goes to the top.
// ----------------------------------------------------------------------------
module type_annotation_target_parser_checker #(
  parameter int LENGTH_BITS = tatp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  record_kind,
  input  logic [7:0]  target_type,
  input  logic [15:0] value_a,
  input  logic [15:0] value_b,
  input  logic [15:0] value_c,
  input  logic [18:0] total_length,
  input  logic [1:0]  error_code,
  input  logic        last,
  output int          fail_count,
  output int          pending
);
  import tatp_pkg::*;

  typedef struct packed {
    kind_t                   kind;
    logic [7:0]              tag;
    logic [15:0]             a;
    logic [15:0]             b;
    logic [15:0]             c;
    logic [LEN_OUT_BITS-1:0] total;
    err_t                    err;
    logic                    last;
  } parse_word_t;

  // Private copy of the parser state
  phase_t                  phase;
  logic [7:0]              held_tag;
  logic [2:0]              field_count;
  logic [15:0]             table_left;
  logic [7:0]              path_left;
  logic [47:0]             shift_bytes;
  logic [LENGTH_BITS-1:0]  byte_total;
  parse_word_t             expected_words [$];

  // Field layout that each target-type tag calls for
  function automatic need_t tag_layout(input logic [7:0] tag);
    case (tag)
      8'h00, 8'h01, 8'h16: return NEED_1;
      8'h10, 8'h11, 8'h12, 8'h17, 8'h42,
      8'h43, 8'h44, 8'h45, 8'h46: return NEED_2;
      8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B: return NEED_3;
      8'h13, 8'h14, 8'h15: return NEED_0;
      8'h40, 8'h41: return NEED_TABLE;
      default: return NEED_BAD;
    endcase
  endfunction

  task automatic queue_word(input kind_t kind, input logic [15:0] a, input logic [15:0] b,
                            input logic [15:0] c, input logic [LEN_OUT_BITS-1:0] total,
                            input err_t err, input logic last_flag);
    parse_word_t w;
    w.kind  = kind;
    w.tag   = held_tag;
    w.a     = a;
    w.b     = b;
    w.c     = c;
    w.total = total;
    w.err   = err;
    w.last  = last_flag;
    expected_words = {expected_words, w};
  endtask

  // Target fields are in: unpack them and move on to the path length
  task automatic complete_target();
    logic [15:0] a;
    logic [15:0] b;
    a = '0;
    b = '0;
    case (tag_layout(held_tag))
      NEED_1: a = {8'h00, shift_bytes[7:0]};
      NEED_2: begin
        if (held_tag == TAG_CLASS_TYPE_PARAM_BOUND ||
            held_tag == TAG_METHOD_TYPE_PARAM_BOUND) begin
          a = {8'h00, shift_bytes[15:8]};
          b = {8'h00, shift_bytes[7:0]};
        end else begin
          a = shift_bytes[15:0];
        end
      end
      NEED_3: begin
        a = shift_bytes[23:8];
        b = {8'h00, shift_bytes[7:0]};
      end
      default: ;
    endcase
    phase = PH_PLEN;
    field_count = '0;
    queue_word(KIND_TARGET, a, b, 16'h0000, '0, ERR_NONE, 1'b0);
  endtask

  // Advance the predicted parse state by one byte
  task automatic parse_byte(input logic [7:0] b);
    logic [7:0]              kind8;
    logic [LEN_OUT_BITS-1:0] len_now;
    err_t                    err;
    // a tag byte restarts the record
    if (phase == PH_TAG) begin
      held_tag    = b;
      byte_total  = LENGTH_BITS'(1);
      field_count = '0;
      shift_bytes = '0;
      table_left  = '0;
      path_left   = '0;
      case (tag_layout(b))
        NEED_BAD: begin
          phase = PH_TAG;
          queue_word(KIND_TARGET, 16'h0000, 16'h0000, 16'h0000, LEN_OUT_BITS'(1),
                     ERR_BAD_TAG, 1'b1);
        end
        NEED_TABLE: phase = PH_TLEN;
        NEED_0: complete_target();
        default: phase = PH_FIELDS;
      endcase
      return;
    end

    // count the byte, saturating, and shift it in
    if (byte_total != '1) byte_total++;
    shift_bytes = {shift_bytes[39:0], b};
    if (byte_total > LEN_OUT_MAX) len_now = LEN_OUT_MAX;
    else len_now = LEN_OUT_BITS'(byte_total);

    case (phase)
      PH_FIELDS: begin
        field_count++;
        if (field_count >= tag_layout(held_tag)) complete_target();
      end
      PH_TLEN: begin
        field_count++;
        if (field_count >= PAIR_BYTES) begin
          field_count = '0;
          table_left = shift_bytes[15:0];
          if (table_left != 0) phase = PH_TENTRY;
          else phase = PH_PLEN;
          queue_word(KIND_TARGET, 16'h0000, table_left, 16'h0000, '0, ERR_NONE, 1'b0);
        end
      end
      PH_TENTRY: begin
        field_count++;
        if (field_count >= TABLE_ENTRY_BYTES) begin
          field_count = '0;
          table_left--;
          if (table_left == 0) phase = PH_PLEN;
          queue_word(KIND_TABLE, shift_bytes[47:32], shift_bytes[31:16], shift_bytes[15:0],
                     '0, ERR_NONE, 1'b0);
        end
      end
      PH_PLEN: begin
        field_count = '0;
        path_left = b;
        if (b == 8'h00) begin
          phase = PH_TAG;
          queue_word(KIND_END, 16'h0000, 16'h0000, 16'h0000, len_now, ERR_NONE, 1'b1);
        end else begin
          phase = PH_PENTRY;
        end
      end
      PH_PENTRY: begin
        field_count++;
        if (field_count >= PAIR_BYTES) begin
          field_count = '0;
          kind8 = shift_bytes[15:8];
          // an argument on the wrong kind wins over a kind out of range
          if (b != 8'h00 && kind8 != MAX_PATH_KIND) err = ERR_BAD_ARG;
          else if (kind8 > MAX_PATH_KIND) err = ERR_BAD_KIND;
          else err = ERR_NONE;
          if (err != ERR_NONE) begin
            phase = PH_TAG;
            queue_word(KIND_PATH, {8'h00, kind8}, {8'h00, b}, 16'h0000, len_now, err, 1'b1);
          end else begin
            path_left--;
            // the final entry rides inside the end word
            if (path_left == 0) begin
              phase = PH_TAG;
              queue_word(KIND_END, {8'h00, kind8}, {8'h00, b}, 16'h0001, len_now,
                         ERR_NONE, 1'b1);
            end else begin
              queue_word(KIND_PATH, {8'h00, kind8}, {8'h00, b}, 16'h0000, '0,
                         ERR_NONE, 1'b0);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [18:0] want_v,
                               input logic [18:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
    end
  endtask

  // Check one taken result word against the oldest expectation
  task automatic check_word();
    parse_word_t want;
    if (expected_words.size() == 0) begin
      fail_count++;
      $display("%0t: result word with nothing expected, kind %0d total_length %0d",
               $time, record_kind, total_length);
      return;
    end
    want = expected_words.pop_front();
    compare_field("record_kind", 19'(want.kind), 19'(record_kind));
    compare_field("target_type", 19'(want.tag), 19'(target_type));
    compare_field("value_a", 19'(want.a), 19'(value_a));
    compare_field("value_b", 19'(want.b), 19'(value_b));
    compare_field("value_c", 19'(want.c), 19'(value_c));
    compare_field("total_length", want.total, total_length);
    compare_field("error_code", 19'(want.err), 19'(error_code));
    compare_field("last", 19'(want.last), 19'(last));
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      phase       = PH_TAG;
      held_tag    = '0;
      field_count = '0;
      table_left  = '0;
      path_left   = '0;
      shift_bytes = '0;
      byte_total  = '0;
      fail_count  = 0;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) check_word();
      if (in_valid && !in_stall) parse_byte(data_byte);
    end
    pending = expected_words.size();
  end

endmodule

// ===== sim/type_annotation_target_parser_core_tb.sv =====
// ----------------------------------------------------------------------------
// type_annotation_target_parser_core_tb: stimulus and verdict for the parser
// Feeds a short run of hand-picked records, then random records: mostly
// well-formed with random content, some with a broken path entry, some bare
// unlisted tags and one path of the largest length. Both channels idle at
// random. The checker beside the block predicts and compares every result
// word.
// ----------------------------------------------------------------------------
module type_annotation_target_parser_core_tb;
  import tatp_pkg::*;

  // Narrow byte counter for the block under test
  localparam int LENGTH_BITS  = 10;
  localparam int ITEM_COUNT   = 850;
  localparam int LONG_PATH    = 255;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  record_kind;
  logic [7:0]  target_type;
  logic [15:0] value_a;
  logic [15:0] value_b;
  logic [15:0] value_c;
  logic [18:0] total_length;
  logic [1:0]  error_code;
  logic        last;
  int          fail_count;
  int          pending;
  int          tx_calm;
  int          rx_calm;
  int          sent_count;
  int          cycle_count;

  // Hand-picked records: field extremes, each error, tables and paths
  logic [7:0] opening_bytes [] = '{
    // single-byte field, sole path entry folded into the end word
    8'h00, 8'hFF, 8'h01, 8'h03, 8'hFF,
    // three-byte fields at their extremes, empty path
    8'h4B, 8'hFF, 8'hFF, 8'h00, 8'h00,
    // split bound indices, then a path kind out of range
    8'h11, 8'hAB, 8'hCD, 8'h02, 8'h00, 8'h00, 8'h04, 8'h00,
    // unlisted tag
    8'hFF,
    // empty table, then an argument on a non-type-argument kind
    8'h40, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01,
    // one table entry at its extremes, empty path
    8'h41, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00,
    // tag with no fields
    8'h13, 8'h00
  };

  type_annotation_target_parser_core #(.LENGTH_BITS(LENGTH_BITS)) uut (.*);

  type_annotation_target_parser_checker #(.LENGTH_BITS(LENGTH_BITS)) parse_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Draw an idle gap, with occasional stretches of none
  task automatic draw_gap(inout int calm, output int gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 24) == 0) calm = $urandom_range(8, 40);
    end
  endtask

  function automatic logic [7:0] field_value();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_tag(input bit listed);
    logic [7:0] t;
    do t = 8'($urandom_range(0, 255));
    while ((field_need(t) != NEED_BAD) != listed);
    return t;
  endfunction

  // Offer one word and hold it until taken; starts and ends on a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    draw_gap(tx_calm, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    sent_count++;
    @(negedge clk);
  endtask

  // Tag and target fields; a table tag takes the given entry count
  task automatic send_target(input logic [7:0] tag, input int entries);
    send_byte(tag);
    case (field_need(tag))
      NEED_BAD: ;
      NEED_TABLE: begin
        send_byte(8'(entries >> 8));
        send_byte(8'(entries));
        repeat (entries * TABLE_ENTRY_BYTES) send_byte(field_value());
      end
      default: repeat (int'(field_need(tag))) send_byte(field_value());
    endcase
  endtask

  // Path length and entries; a spoilt path breaks off at its bad entry
  task automatic send_path(input int entries, input bit spoil);
    int         bad_at;
    logic [7:0] kind;
    logic [7:0] arg;
    send_byte(8'(entries));
    bad_at = spoil ? $urandom_range(0, entries - 1) : -1;
    for (int i = 0; i < entries; i++) begin
      kind = 8'($urandom_range(0, MAX_PATH_KIND));
      arg  = (kind == MAX_PATH_KIND) ? field_value() : 8'h00;
      if (i == bad_at) begin
        case ($urandom_range(0, 2))
          0: begin
            kind = 8'($urandom_range(4, 255));
            arg  = 8'h00;
          end
          1: begin
            kind = 8'($urandom_range(0, 2));
            arg  = 8'($urandom_range(1, 255));
          end
          default: begin
            kind = 8'($urandom_range(4, 255));
            arg  = 8'($urandom_range(1, 255));
          end
        endcase
      end
      send_byte(kind);
      send_byte(arg);
      if (i == bad_at) break;
    end
  endtask

  task automatic send_random_record();
    int         pick;
    int         entries;
    int         plen;
    logic [7:0] tag;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_byte(pick_tag(1'b0));
    end else begin
      tag = pick_tag(1'b1);
      entries = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      send_target(tag, entries);
      pick = $urandom_range(0, 9);
      if (pick < 2) plen = 0;
      else if (pick < 9) plen = $urandom_range(1, 3);
      else plen = $urandom_range(4, 10);
      send_path(plen, plen > 0 && $urandom_range(0, 7) == 0);
    end
  endtask

  // Result side: stall for a random gap before taking each word
  initial begin
    int gap;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      draw_gap(rx_calm, gap);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Give up if the run reaches CYCLE_LIMIT
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("type_annotation_target_parser_core test failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int rec;
    rst        = 1'b1;
    in_valid   = 1'b0;
    data_byte  = 8'h00;
    tx_calm    = 0;
    rx_calm    = 0;
    sent_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

    // random records, with the long path placed among them
    rec = 0;
    while (sent_count < ITEM_COUNT) begin
      if (rec == 12) begin
        send_target(8'h13, 0);
        send_path(LONG_PATH, 1'b0);
      end else begin
        send_random_record();
      end
      rec++;
    end
    in_valid <= 1'b0;

    // drain, then allow the pipeline to settle
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("type_annotation_target_parser_core test passed");
    end else begin
      $display("type_annotation_target_parser_core test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tatp_pkg.sv
hdl/tatp_step.sv
hdl/type_annotation_target_parser_core.sv
sim/type_annotation_target_parser_checker.sv
sim/type_annotation_target_parser_core_tb.sv
